@@ rtl/tpq_pkg.sv @@
// shared constants and types for the two-class priority request queue
package tpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 10;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam int OCC_W      = 5;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_POLICY    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAP_LIMIT = 1'd1;

    // policy codes
    localparam logic [1:0] POLICY_FIFO    = 2'd0;
    localparam logic [1:0] POLICY_STATIC  = 2'd1;
    localparam logic [1:0] POLICY_DYNAMIC = 2'd2;

    localparam logic [CFG_DATA_W-1:0] CAP_LIMIT_RESET = 5'd16;

    // input modes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // per-beat control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
        logic prio_en;
        logic want_static;
        logic fallback;
    } tpq_ctl_t;

    // signals rippling from a cell to the next one up
    typedef struct packed {
        logic found;
        logic shift;
    } tpq_link_t;

endpackage

@@ rtl/tpq_cell.sv @@
// one queue slot: holds an entry, finds the pick, shifts down on removal
module tpq_cell #(
    parameter int IDX     = 0,
    parameter int ID_BITS = tpq_pkg::DEF_ID_BITS,
    parameter int CNT_W   = 5
) (
    input  logic                aclk,
    input  logic [CNT_W-1:0]    count,
    input  tpq_pkg::tpq_ctl_t   ctl,
    input  logic [ID_BITS-1:0]  push_id,
    input  logic                push_cls,
    input  logic [ID_BITS-1:0]  upper_id,
    input  logic                upper_cls,
    input  tpq_pkg::tpq_link_t  link_in,
    output tpq_pkg::tpq_link_t  link_out,
    input  logic [ID_BITS-1:0]  pid_in,
    output logic [ID_BITS-1:0]  pid_out,
    output logic [ID_BITS-1:0]  id_out,
    output logic                cls_out
);
    import tpq_pkg::*;

    logic [ID_BITS-1:0] id_reg;
    logic               cls_reg;
    logic               occ;
    logic               match;
    logic               pick;
    logic               shift_here;
    logic               is_tail;

    assign occ     = CNT_W'(IDX) < count;
    assign is_tail = CNT_W'(IDX) == count;
    assign match   = occ && (cls_reg == ctl.want_static);

    // first matching slot wins; slot 0 also takes the fallback pick
    assign pick = (ctl.prio_en && match && !link_in.found)
                  || ((IDX == 0) && ctl.fallback);

    assign shift_here     = link_in.shift || pick;
    assign link_out.found = link_in.found || match;
    assign link_out.shift = shift_here;

    assign pid_out = pick ? id_reg : pid_in;
    assign id_out  = id_reg;
    assign cls_out = cls_reg;

    always_ff @(posedge aclk) begin
        if (ctl.pop && shift_here) begin
            id_reg  <= upper_id;
            cls_reg <= upper_cls;
        end else if (ctl.push && is_tail) begin
            id_reg  <= push_id;
            cls_reg <= push_cls;
        end
    end

endmodule

@@ rtl/two_class_priority_request_queue.sv @@
// top level: two-class priority request queue built as a row of shifting cells
//
//  channel   dir  handshake             payload
//  s_*       in   s_valid / s_ready     s_mode, s_conn_id, s_static_req
//  m_*       out  m_valid / m_ready     m_accepted, m_was_empty, m_popped_id, m_occupancy
//  cfg_*     in   cfg_wr_en             cfg_addr, cfg_wdata
//
// one beat per cycle while s_ready is high: a push or pop is applied to the cell row in
// the cycle it is accepted; its result appears in the output register on the next cycle.
// the pick search and the popped id ripple combinationally through the cells.
// s_ready is high while the output register is empty or being drained.
// synchronous active-low reset empties the queue; no clearing pass is needed.
module two_class_priority_request_queue #(
    parameter int QUEUE_DEPTH = tpq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = tpq_pkg::DEF_ID_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [ID_BITS-1:0]              s_conn_id,
    input  logic                            s_static_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_accepted,
    output logic                            m_was_empty,
    output logic [ID_BITS-1:0]              m_popped_id,
    output logic [tpq_pkg::OCC_W-1:0]       m_occupancy,
    input  logic                            cfg_wr_en,
    input  logic [tpq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tpq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]            policy_reg;
    logic [CFG_DATA_W-1:0] cap_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic                  m_valid_reg;
    logic                  accepted_reg;
    logic                  was_empty_reg;
    logic [ID_BITS-1:0]    popped_reg;
    logic [OCC_W-1:0]      occ_reg;

    logic                  fire;
    logic                  can_push;
    logic                  do_push;
    logic                  do_pop;
    logic                  prio_en;
    tpq_ctl_t              ctl;

    tpq_link_t             link [0:QUEUE_DEPTH];
    logic [ID_BITS-1:0]    pid  [0:QUEUE_DEPTH];
    logic [ID_BITS-1:0]    cid  [0:QUEUE_DEPTH];
    logic                  ccls [0:QUEUE_DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    // limit above the depth is clamped by the second compare
    assign can_push = (32'(count_reg) < 32'(cap_reg))
                      && (32'(count_reg) < QUEUE_DEPTH);
    assign do_push  = fire && (s_mode == MODE_PUSH) && can_push;
    assign do_pop   = fire && (s_mode == MODE_POP) && (count_reg != '0);

    assign prio_en  = (policy_reg == POLICY_STATIC) || (policy_reg == POLICY_DYNAMIC);

    always_comb begin
        ctl.push        = do_push;
        ctl.pop         = do_pop;
        ctl.prio_en     = prio_en;
        ctl.want_static = (policy_reg == POLICY_STATIC);
        // priority off or no entry of the preferred class: take the oldest
        ctl.fallback    = !(prio_en && link[QUEUE_DEPTH].found);
    end

    assign link[0] = '{found: 1'b0, shift: 1'b0};
    assign pid[0]  = '0;
    assign cid[QUEUE_DEPTH]  = '0;
    assign ccls[QUEUE_DEPTH] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        tpq_cell #(
            .IDX     (i),
            .ID_BITS (ID_BITS),
            .CNT_W   (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .count     (count_reg),
            .ctl       (ctl),
            .push_id   (s_conn_id),
            .push_cls  (s_static_req),
            .upper_id  (cid[i+1]),
            .upper_cls (ccls[i+1]),
            .link_in   (link[i]),
            .link_out  (link[i+1]),
            .pid_in    (pid[i]),
            .pid_out   (pid[i+1]),
            .id_out    (cid[i]),
            .cls_out   (ccls[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (do_push) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POLICY_FIFO;
            cap_reg    <= CAP_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_POLICY:    policy_reg <= cfg_wdata[1:0];
                REG_CAP_LIMIT: cap_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            accepted_reg  <= do_push || do_pop;
            was_empty_reg <= (s_mode == MODE_POP) && (count_reg == '0);
            popped_reg    <= do_pop ? pid[QUEUE_DEPTH] : '0;
            occ_reg       <= OCC_W'(32'(count_next));
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_accepted  = accepted_reg;
    assign m_was_empty = was_empty_reg;
    assign m_popped_id = popped_reg;
    assign m_occupancy = occ_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// testbench for the two-class priority request queue: response scoreboard and stimulus tasks

typedef struct packed {
    logic                               accepted;
    logic                               was_empty;
    logic [tpq_pkg::DEF_ID_BITS-1:0]    popped_id;
    logic [tpq_pkg::OCC_W-1:0]          occupancy;
} queue_response_t;

class request_queue_scoreboard;
    // class bit on top of each held entry, oldest first
    logic [tpq_pkg::DEF_ID_BITS:0]  held[$];
    logic [1:0]                     policy;
    logic [tpq_pkg::CFG_DATA_W-1:0] cap_limit;
    queue_response_t                awaited[$];
    int                             mismatches;

    function new();
        policy     = tpq_pkg::POLICY_FIFO;
        cap_limit  = tpq_pkg::CAP_LIMIT_RESET;
        mismatches = 0;
    endfunction

    function void set_policy(logic [1:0] value);
        policy = value;
    endfunction

    function void set_limit(logic [tpq_pkg::CFG_DATA_W-1:0] value);
        cap_limit = value;
    endfunction

    function int outstanding();
        return awaited.size();
    endfunction

    function void note_request(logic mode, logic [tpq_pkg::DEF_ID_BITS-1:0] conn_id,
                               logic static_req);
        queue_response_t resp;
        int room;
        int slot;
        logic want_static;
        resp = '0;
        room = (cap_limit > tpq_pkg::DEF_QUEUE_DEPTH) ? tpq_pkg::DEF_QUEUE_DEPTH : cap_limit;
        if (mode == tpq_pkg::MODE_PUSH) begin
            if (held.size() < room) begin
                held.push_back({static_req, conn_id});
                resp.accepted = 1'b1;
            end
        end else if (held.size() == 0) begin
            resp.was_empty = 1'b1;
        end else begin
            // oldest of the preferred class, else oldest overall
            slot = 0;
            if (policy == tpq_pkg::POLICY_STATIC || policy == tpq_pkg::POLICY_DYNAMIC) begin
                want_static = (policy == tpq_pkg::POLICY_STATIC);
                for (int i = held.size() - 1; i >= 0; i--) begin
                    if (held[i][tpq_pkg::DEF_ID_BITS] == want_static)
                        slot = i;
                end
            end
            resp.popped_id = held[slot][tpq_pkg::DEF_ID_BITS-1:0];
            held.delete(slot);
            resp.accepted = 1'b1;
        end
        resp.occupancy = tpq_pkg::OCC_W'(held.size());
        awaited.push_back(resp);
    endfunction

    function void check_response(queue_response_t got);
        queue_response_t want;
        if (awaited.size() == 0) begin
            $error("result beat with nothing outstanding: accepted %0d was_empty %0d id %0d occ %0d",
                   got.accepted, got.was_empty, got.popped_id, got.occupancy);
            mismatches++;
            return;
        end
        want = awaited.pop_front();
        if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            mismatches++;
        end
        if (got.was_empty !== want.was_empty) begin
            $error("was_empty: expected %0d, got %0d", want.was_empty, got.was_empty);
            mismatches++;
        end
        if (got.popped_id !== want.popped_id) begin
            $error("popped_id: expected %0d, got %0d", want.popped_id, got.popped_id);
            mismatches++;
        end
        if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    import tpq_pkg::*;

    localparam int ID_W        = DEF_ID_BITS;
    localparam int STALL_LIMIT = 2000;
    // unused policy code, behaves as plain fifo
    localparam logic [1:0] POLICY_SPARE = 2'd3;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic                   s_mode       = MODE_PUSH;
    logic [ID_W-1:0]        s_conn_id    = '0;
    logic                   s_static_req = 1'b0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic                   m_accepted;
    logic                   m_was_empty;
    logic [ID_W-1:0]        m_popped_id;
    logic [OCC_W-1:0]       m_occupancy;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr     = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;

    request_queue_scoreboard tracker = new();

    bit calm = 1'b0;
    int rx_hold = 0;
    int quiet_cycles = 0;

    two_class_priority_request_queue u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_conn_id    (s_conn_id),
        .s_static_req (s_static_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_was_empty  (m_was_empty),
        .m_popped_id  (m_popped_id),
        .m_occupancy  (m_occupancy),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_request(input logic mode, input logic [ID_W-1:0] conn_id,
                                input logic static_req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_conn_id    <= conn_id;
        s_static_req <= static_req;
        do @(posedge aclk); while (!(s_valid && s_ready));
        tracker.note_request(mode, conn_id, static_req);
    endtask

    // sender stops until every outstanding result beat is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [1:0] policy, input logic [CFG_DATA_W-1:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_POLICY;
        cfg_wdata <= CFG_DATA_W'(policy);
        @(posedge aclk);
        tracker.set_policy(policy);
        cfg_addr  <= REG_CAP_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        tracker.set_limit(limit);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_traffic(input int count);
        int left;
        int burst;
        int pop_pct;
        left = count;
        while (left > 0) begin
            // bursts lean toward filling, draining or churning the queue
            burst = $urandom_range(8, 24);
            case ($urandom_range(0, 2))
                0: begin
                    pop_pct = 15;
                end
                1: begin
                    pop_pct = 50;
                end
                default: begin
                    pop_pct = 85;
                end
            endcase
            for (int k = 0; k < burst && left > 0; k++) begin
                send_request(($urandom_range(0, 99) < pop_pct) ? MODE_POP : MODE_PUSH,
                             ID_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
                left--;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_response(queue_response_t'{m_accepted, m_was_empty,
                                                     m_popped_id, m_occupancy});
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [ID_W-1:0]       conn_id;
        logic [1:0]            policy;
        logic [CFG_DATA_W-1:0] limit;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: empty pop, fill with extreme ids, refused push when full
        send_request(MODE_POP, '0, 1'b0);
        for (int i = 0; i < DEF_QUEUE_DEPTH; i++) begin
            conn_id = (i == 0) ? '0 : (i == 1) ? '1 : ID_W'($urandom_range(0, 1023));
            send_request(MODE_PUSH, conn_id, i[0] ^ i[2]);
        end
        send_request(MODE_PUSH, 10'h2aa, 1'b1);

        // limit dropped below occupancy, then policy switched with entries held
        wait_idle();
        apply_settings(POLICY_STATIC, 5'd3);
        send_request(MODE_PUSH, 10'h155, 1'b0);
        repeat (3) send_request(MODE_POP, '1, 1'b1);
        wait_idle();
        apply_settings(POLICY_DYNAMIC, 5'd0);
        send_request(MODE_PUSH, 10'h3ff, 1'b0);
        repeat (2) send_request(MODE_POP, '0, 1'b0);

        for (int phase = 0; phase < 16; phase++) begin
            wait_idle();
            calm = (phase % 4 == 2);
            case (phase)
                0: begin
                    policy = POLICY_FIFO;
                    limit  = 5'd1;
                end
                1: begin
                    policy = POLICY_STATIC;
                    limit  = 5'd16;
                end
                2: begin
                    policy = POLICY_DYNAMIC;
                    limit  = 5'd31;
                end
                3: begin
                    policy = POLICY_SPARE;
                    limit  = 5'd17;
                end
                4: begin
                    policy = POLICY_STATIC;
                    limit  = 5'd0;
                end
                default: begin
                    policy = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 5))
                        0: limit = 5'd0;
                        1: limit = 5'd1;
                        2: limit = 5'd16;
                        3: limit = 5'd31;
                        default: limit = CFG_DATA_W'($urandom_range(2, 15));
                    endcase
                end
            endcase
            apply_settings(policy, limit);
            run_traffic(100);
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ two_class_priority_request_queue.f @@
rtl/tpq_pkg.sv
rtl/tpq_cell.sv
rtl/two_class_priority_request_queue.sv
tb/testbench.sv
